[rtl/wgk_pkg.sv]
`default_nettype none
package wgk_pkg;

  // input operations
  localparam logic [1:0] OP_LOAD_W   = 2'd0;
  localparam logic [1:0] OP_LOAD_Q   = 2'd1;
  localparam logic [1:0] OP_ROW_ELEM = 2'd2;

  // result kinds
  localparam logic KIND_KERNEL = 1'b0;
  localparam logic KIND_DERIV  = 1'b1;

  // config register indexes
  localparam logic [1:0] REG_INV_SCALE = 2'd0;
  localparam logic [1:0] REG_DIM       = 2'd1;
  localparam logic [1:0] REG_EMIT_DER  = 2'd2;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [22:0] Y_CAP     = 23'd4194304;   // 64.0 in Q.16
  localparam logic [31:0] STEP_Q32  = 32'd4283353945;

  // one row element handed from front to back
  typedef struct packed {
    logic [4:0]         coord;
    logic               first;
    logic               last;
    logic signed [15:0] w;
    logic signed [16:0] diff;    // x - v
  } elem_t;

  typedef logic [16:0] tab_t [256];

  // 2^(-i/256) in Q1.16, built by repeated Q0.32 multiplication
  function automatic tab_t build_exp_tab();
    logic [127:0] acc;
    tab_t         t;
    acc = 128'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      t[i] = 17'((acc + 128'd32768) >> 16);
      acc  = (acc * {96'd0, STEP_Q32}) >> 32;
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

[rtl/wgk_front.sv]
`default_nettype none
module wgk_front #(
  parameter int MAX_DIM = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_op,
  input  wire logic [4:0]    in_coord,
  input  wire logic [15:0]   in_value,
  input  wire logic [5:0]    dim,
  output logic               q_valid,
  output wgk_pkg::elem_t     q_data,
  input  wire logic          q_pop
);
  import wgk_pkg::*;

  localparam int DEPTH = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QD    = 4;

  logic signed [15:0] w_mem [DEPTH];
  logic signed [15:0] v_mem [DEPTH];

  elem_t      fifo_r [QD];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  logic  acc_in, store_ok, push;
  elem_t elem;

  assign in_ready = (cnt_r != 3'(QD));
  assign acc_in   = in_valid && in_ready;
  assign store_ok = ({1'b0, in_coord} < 6'(MAX_DIM));
  assign push     = acc_in && (in_op == OP_ROW_ELEM) && ({1'b0, in_coord} < dim);

  // classify a row element and fetch its weight and query value
  always_comb begin
    elem.coord = in_coord;
    elem.first = (in_coord == 5'd0);
    elem.last  = ({1'b0, in_coord} == dim - 6'd1);
    elem.w     = w_mem[in_coord[IW-1:0]];
    elem.diff  = {in_value[15], in_value} - {v_mem[in_coord[IW-1:0]][15],
                                             v_mem[in_coord[IW-1:0]]};
  end

  // weight and query stores
  always_ff @(posedge clk) begin
    if (acc_in && store_ok) begin
      if (in_op == OP_LOAD_W) w_mem[in_coord[IW-1:0]] <= in_value;
      if (in_op == OP_LOAD_Q) v_mem[in_coord[IW-1:0]] <= in_value;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= elem;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)  wr_ptr_r <= wr_ptr_r + 2'd1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      if (push && !q_pop)      cnt_r <= cnt_r + 3'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 3'd1;
    end
  end

  assign q_valid = (cnt_r != 3'd0);
  assign q_data  = fifo_r[rd_ptr_r];

endmodule
`default_nettype wire

[rtl/wgk_back.sv]
`default_nettype none
module wgk_back #(
  parameter int MAX_DIM = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire wgk_pkg::elem_t q_data,
  output logic               q_pop,
  input  wire logic [23:0]   inv_scale,
  input  wire logic [5:0]    dim,
  input  wire logic          emit_derivative,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [4:0]         out_index,
  output logic [31:0]        out_value,
  output logic               out_last
);
  import wgk_pkg::*;

  localparam int DEPTH = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_K1   = 4'd3;
  localparam logic [3:0] S_K2   = 4'd4;
  localparam logic [3:0] S_K3   = 4'd5;
  localparam logic [3:0] S_K4   = 4'd6;
  localparam logic [3:0] S_K5   = 4'd7;
  localparam logic [3:0] S_EK   = 4'd8;
  localparam logic [3:0] S_D1   = 4'd9;
  localparam logic [3:0] S_D2   = 4'd10;
  localparam logic [3:0] S_D3   = 4'd11;
  localparam logic [3:0] S_D4   = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic signed [20:0] wd_mem [DEPTH];

  logic signed [32:0] p_r;
  logic [4:0]  coord_r;
  logic        first_r, last_r;
  logic [40:0] sq_r;
  logic [55:0] acc_r, acc_nxt;
  logic [55:0] mh_r;
  logic [47:0] ml_r;
  logic [22:0] y_r;
  logic [23:0] z_r;
  logic [15:0] k_r;
  logic [39:0] ik_r;
  logic [20:0] mag_r;
  logic        pos_r;
  logic [40:0] pl_r, ph_r;
  logic [31:0] res_r;
  logic [4:0]  j_r;

  logic        out_free;
  logic signed [32:0] wv, dv;
  logic signed [20:0] wd, wdj;
  logic signed [41:0] wd_ext, sq_full;
  logic [56:0] acc_sum, y_sum;
  logic [39:0] z_full;
  logic [7:0]  n_int;
  logic [16:0] t_shift;
  logic [60:0] m_full;
  logic [33:0] q_rnd;
  logic        j_last;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign j_last   = ({1'b0, j_r} == dim - 6'd1);

  // datapath helpers
  always_comb begin
    wv      = {{17{q_data.w[15]}}, q_data.w};
    dv      = {{16{q_data.diff[16]}}, q_data.diff};
    wd      = 21'(p_r >>> 12);
    wd_ext  = {{21{wd[20]}}, wd};
    sq_full = wd_ext * wd_ext;
    acc_sum = {1'b0, (first_r ? 56'd0 : acc_r)} + {16'd0, sq_r};
    acc_nxt = acc_sum[56] ? {56{1'b1}} : acc_sum[55:0];
    y_sum   = {1'b0, mh_r} + {33'd0, ml_r[47:24]};
    z_full  = {17'd0, y_r} * {23'd0, LOG2E_Q16};
    n_int   = z_r[23:16];
    t_shift = EXP_TAB[z_r[15:8]] >> n_int[3:0];
    wdj     = wd_mem[j_r[IW-1:0]];
    m_full  = ({20'd0, ph_r} << 20) + {20'd0, pl_r};
    q_rnd   = 34'((m_full + 61'd67108864) >> 27);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_K1 : S_IDLE;
      S_K1:   state_nxt = S_K2;
      S_K2:   state_nxt = S_K3;
      S_K3:   state_nxt = S_K4;
      S_K4:   state_nxt = S_K5;
      S_K5:   state_nxt = S_EK;
      S_EK:   if (out_free) state_nxt = emit_derivative ? S_D1 : S_IDLE;
      S_D1:   state_nxt = S_D2;
      S_D2:   state_nxt = S_D3;
      S_D3:   state_nxt = S_D4;
      S_D4:   if (out_free) state_nxt = j_last ? S_IDLE : S_D1;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // accumulator and row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      j_r   <= '0;
    end else begin
      if (state_r == S_ACC) acc_r <= acc_nxt;
      if (state_r == S_K1)  acc_r <= '0;
      if (state_r == S_EK)  j_r   <= '0;
      if (state_r == S_D4 && out_free) j_r <= j_r + 5'd1;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_r     <= wv * dv;
      coord_r <= q_data.coord;
      first_r <= q_data.first;
      last_r  <= q_data.last;
    end
    if (state_r == S_SQ) begin
      wd_mem[coord_r[IW-1:0]] <= wd;
      sq_r <= sq_full[40:0];
    end
    if (state_r == S_K1) begin
      mh_r <= {24'd0, acc_r[55:24]} * {32'd0, inv_scale};
      ml_r <= {24'd0, acc_r[23:0]} * {24'd0, inv_scale};
    end
    if (state_r == S_K2) y_r <= (y_sum > {34'd0, Y_CAP}) ? Y_CAP : y_sum[22:0];
    if (state_r == S_K3) z_r <= z_full[39:16];
    if (state_r == S_K4) begin
      if (n_int >= 8'd16)  k_r <= 16'd0;
      else if (t_shift[16]) k_r <= 16'hFFFF;
      else                 k_r <= t_shift[15:0];
    end
    if (state_r == S_K5) ik_r <= {16'd0, inv_scale} * {24'd0, k_r};
    if (state_r == S_D1) begin
      pos_r <= (wdj > 21'sd0);
      mag_r <= wdj[20] ? 21'(-wdj) : wdj;
    end
    if (state_r == S_D2) begin
      pl_r <= {21'd0, ik_r[19:0]} * {20'd0, mag_r};
      ph_r <= {21'd0, ik_r[39:20]} * {20'd0, mag_r};
    end
    if (state_r == S_D3) begin
      if (pos_r) res_r <= (q_rnd > 34'h080000000) ? 32'h80000000 : 32'(34'd0 - q_rnd);
      else       res_r <= (q_rnd > 34'h07FFFFFFF) ? 32'h7FFFFFFF : q_rnd[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_EK && out_free) begin
      out_valid <= 1'b1;
    end else if (state_r == S_D4 && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EK && out_free) begin
      out_kind  <= KIND_KERNEL;
      out_index <= 5'd0;
      out_value <= {16'd0, k_r};
      out_last  <= !emit_derivative;
    end else if (state_r == S_D4 && out_free) begin
      out_kind  <= KIND_DERIV;
      out_index <= j_r;
      out_value <= res_r;
      out_last  <= j_last;
    end
  end

endmodule
`default_nettype wire

[rtl/weighted_gaussian_kernel_row.sv]
`default_nettype none
// Weighted Gaussian kernel over one data row.
// in_*  : input words. tdata = operation[1:0], coord[6:2], value[22:7].
//         Operation 0 loads a weight, 1 a query element, 2 is a row element.
// out_* : results. tdata = index[4:0], result_value[36:5]; tuser = kind;
//         tlast marks the final result of a row.
// cfg_* : register writes (0 inv_scale, 1 dim_in_use, 2 emit_derivative),
//         always ready; write only while the block is idle.
// Loads never stall unless the element queue is full.
// A row element passes the back end as product, square and accumulate;
// the row end runs the exp path and then emits one kernel word,
// followed in derivative mode by one word per coordinate, each through
// the split 40x21 multiply in the back end.
// A 4-word queue between front and back lets input keep flowing while the
// back end works. When the receiver stalls, the output register holds its
// word and the back end stops at its next result; the queue then fills and
// in_tready drops. Reset clears the queue, accumulator and registers
// (inv_scale 1.0, dim 32, no derivative); weight and query stores are
// undefined until loaded.
module weighted_gaussian_kernel_row #(
  parameter int MAX_DIM = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // operation, coord, value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // index, result_value
  output logic             out_tuser,  // kind
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import wgk_pkg::*;

  localparam int DEPTH = (MAX_DIM < 32) ? MAX_DIM : 32;

  logic [23:0] inv_scale_r;
  logic [5:0]  dim_in_use_r;
  logic        emit_der_r;
  logic [5:0]  dim;

  logic        q_valid, q_pop;
  elem_t       q_data;
  logic [4:0]  res_index;
  logic [31:0] res_value;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_scale_r  <= 24'd65536;
      dim_in_use_r <= 6'd32;
      emit_der_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_SCALE: inv_scale_r  <= cfg_data;
        REG_DIM:       dim_in_use_r <= cfg_data[5:0];
        REG_EMIT_DER:  emit_der_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective dimension
  assign dim = (dim_in_use_r > 6'(DEPTH)) ? 6'(DEPTH) : dim_in_use_r;

  wgk_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tdata[1:0]),
    .in_coord (in_tdata[6:2]),
    .in_value (in_tdata[22:7]),
    .dim      (dim),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  wgk_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .inv_scale       (inv_scale_r),
    .dim             (dim),
    .emit_derivative (emit_der_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_kind        (out_tuser),
    .out_index       (res_index),
    .out_value       (res_value),
    .out_last        (out_tlast)
  );

  assign out_tdata = {3'd0, res_value, res_index};

endmodule
`default_nettype wire
